[sv/hpt_pkg.sv]
// Shared types and constants for the homogeneous point transform.
`default_nettype none
package hpt_pkg;
    localparam int Q_W        = 32;               // Q16.16 word
    localparam int FRAC_W     = 16;
    localparam int CFG_W      = 64;
    localparam int NUM_REGS   = 8;
    localparam int IDX_W      = 8;
    localparam int SUM_W      = 50;               // Q34.16 column sum
    localparam int REM_W      = SUM_W + 32;       // divider remainder
    localparam int QB         = 31;               // quotient bits below the overflow test
    localparam int DIV_STAGES = QB + 1;
    localparam int PIPE_LAT   = 3 + DIV_STAGES + 1;

    localparam logic [CFG_W-1:0] ONE_LO = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] ONE_HI = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic vld;
        logic wz;
    } side_t;
endpackage
`default_nettype wire

[sv/hpt_mac.sv]
// One matrix column: three products, floor to Q16.16, plus the row 4 entry.
`default_nettype none
module hpt_mac
(
    input  wire logic                               clk,
    input  wire logic signed [hpt_pkg::Q_W-1:0]     px,
    input  wire logic signed [hpt_pkg::Q_W-1:0]     py,
    input  wire logic signed [hpt_pkg::Q_W-1:0]     pz,
    input  wire logic signed [hpt_pkg::Q_W-1:0]     ma,
    input  wire logic signed [hpt_pkg::Q_W-1:0]     mb,
    input  wire logic signed [hpt_pkg::Q_W-1:0]     mc,
    input  wire logic signed [hpt_pkg::Q_W-1:0]     mt,
    output logic signed [hpt_pkg::SUM_W-1:0]        sum
);
    import hpt_pkg::*;

    logic signed [2*Q_W-1:0] pa_reg, pb_reg, pc_reg;
    logic signed [Q_W-1:0]   mt_reg;
    logic signed [2*Q_W-1:0] fa, fb, fc;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        pa_reg <= px * ma;
        pb_reg <= py * mb;
        pc_reg <= pz * mc;
        mt_reg <= mt;
    end

    always_comb
    begin
        fa = pa_reg >>> FRAC_W;
        fb = pb_reg >>> FRAC_W;
        fc = pc_reg >>> FRAC_W;
        sum_next = fa[SUM_W-1:0] + fb[SUM_W-1:0] + fc[SUM_W-1:0]
                 + {{(SUM_W-Q_W){mt_reg[Q_W-1]}}, mt_reg};
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum = sum_reg;
endmodule
`default_nettype wire

[sv/hpt_div.sv]
// Pipelined restoring divider: an overflow test stage, then one quotient bit per stage, with saturation.
`default_nettype none
module hpt_div
(
    input  wire logic                            clk,
    input  wire logic [hpt_pkg::SUM_W-1:0]       num_mag,
    input  wire logic [hpt_pkg::SUM_W-1:0]       den_mag,
    input  wire logic                            neg,
    output logic signed [hpt_pkg::Q_W-1:0]       quo
);
    import hpt_pkg::*;

    logic [REM_W-1:0] rem_reg [0:DIV_STAGES-1];
    logic [SUM_W-1:0] den_reg [0:DIV_STAGES-1];
    logic [QB-1:0]    q_reg   [0:DIV_STAGES-1];
    logic             neg_reg [0:DIV_STAGES-1];
    logic             ovf_reg [0:DIV_STAGES-1];

    logic [REM_W-1:0] dividend;
    logic [REM_W-1:0] den_top;

    // stage 0: magnitude of at least 2^31 saturates
    always_comb
    begin
        dividend = {{(REM_W-SUM_W){1'b0}}, num_mag} << FRAC_W;
        den_top  = {{(REM_W-SUM_W){1'b0}}, den_mag} << QB;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= dividend;
        den_reg[0] <= den_mag;
        q_reg[0]   <= '0;
        neg_reg[0] <= neg;
        ovf_reg[0] <= (dividend >= den_top);
    end

    for (genvar s = 1; s < DIV_STAGES; s++)
    begin : g_stage
        localparam int K = QB - s;
        logic [REM_W-1:0] dsh;
        logic [REM_W:0]   diff;
        always_comb
        begin
            dsh  = {{(REM_W-SUM_W){1'b0}}, den_reg[s-1]} << K;
            diff = {1'b0, rem_reg[s-1]} - {1'b0, dsh};
        end
        always_ff @(posedge clk)
        begin
            den_reg[s] <= den_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
            ovf_reg[s] <= ovf_reg[s-1];
            if (!diff[REM_W])
            begin
                rem_reg[s] <= diff[REM_W-1:0];
                q_reg[s]   <= q_reg[s-1] | (QB'(1) << K);
            end
            else
            begin
                rem_reg[s] <= rem_reg[s-1];
                q_reg[s]   <= q_reg[s-1];
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[DIV_STAGES-1])
            quo = neg_reg[DIV_STAGES-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        else if (neg_reg[DIV_STAGES-1])
            quo = -$signed({1'b0, q_reg[DIV_STAGES-1]});
        else
            quo = $signed({1'b0, q_reg[DIV_STAGES-1]});
    end
endmodule
`default_nettype wire

[sv/homogeneous_point_transform.sv]
// Top level: 4x4 homogeneous point transform with perspective divide, Q16.16.
`default_nettype none
//  channel   signals                                  handshake
//  request   point_x, point_y, point_z                start (busy is always low)
//  result    result_x, result_y, result_z, w_zero     done, one-cycle strobe
//  config    wr_index, wr_data                        wr_en, no wait
//
//  One request per cycle. Each result passes through one multiply stage, one
//  sum stage, one magnitude stage, 32 divider stages (the overflow test, then
//  one quotient bit each) and the output register.
//  The sign-magnitude divider is the deep part and sets the latency.
//  Reset clears the matrix to identity and empties the valid pipeline.
//  The result side cannot stall, so the pipeline advances every cycle.
module homogeneous_point_transform
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [hpt_pkg::Q_W-1:0]    point_x,
    input  wire logic signed [hpt_pkg::Q_W-1:0]    point_y,
    input  wire logic signed [hpt_pkg::Q_W-1:0]    point_z,
    output logic                                   done,
    output logic signed [hpt_pkg::Q_W-1:0]         result_x,
    output logic signed [hpt_pkg::Q_W-1:0]         result_y,
    output logic signed [hpt_pkg::Q_W-1:0]         result_z,
    output logic                                   w_zero,
    input  wire logic                              wr_en,
    input  wire logic [hpt_pkg::IDX_W-1:0]         wr_index,
    input  wire logic [hpt_pkg::CFG_W-1:0]         wr_data
);
    import hpt_pkg::*;

    logic [CFG_W-1:0] mat_reg [0:NUM_REGS-1];
    logic signed [Q_W-1:0] m [0:3][0:3];        // m[row][col], zero based
    logic [1:0] vld_reg;                        // multiply and sum stages
    side_t side_reg [0:DIV_STAGES];             // magnitude stage onward

    logic signed [SUM_W-1:0] col_sum [0:3];
    logic [SUM_W-1:0] nmag_reg [0:2];
    logic             nneg_reg [0:2];
    logic [SUM_W-1:0] wmag_reg;
    logic signed [Q_W-1:0] quo [0:2];

    logic                  done_reg;
    logic                  wz_reg;
    logic signed [Q_W-1:0] rx_reg, ry_reg, rz_reg;

    assign busy = 1'b0;

    // configuration: writes beyond the matrix are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= ONE_LO;
            mat_reg[1] <= '0;
            mat_reg[2] <= ONE_HI;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= ONE_LO;
            mat_reg[6] <= '0;
            mat_reg[7] <= ONE_HI;
        end
        else if (wr_en && (wr_index < IDX_W'(NUM_REGS)))
        begin
            mat_reg[wr_index[2:0]] <= wr_data;
        end
    end

    // each register holds two neighboring entries of a row
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                m[r][c] = (c % 2 == 1) ? mat_reg[r*2 + c/2][CFG_W-1:Q_W]
                                       : mat_reg[r*2 + c/2][Q_W-1:0];
            end
        end
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_col
        hpt_mac u_mac
        (
            .clk (clk),
            .px  (point_x),
            .py  (point_y),
            .pz  (point_z),
            .ma  (m[0][c]),
            .mb  (m[1][c]),
            .mc  (m[2][c]),
            .mt  (m[3][c]),
            .sum (col_sum[c])
        );
    end

    // magnitudes and quotient signs
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            nmag_reg[i] <= col_sum[i][SUM_W-1] ? SUM_W'(-col_sum[i]) : SUM_W'(col_sum[i]);
            nneg_reg[i] <= col_sum[i][SUM_W-1] ^ col_sum[3][SUM_W-1];
        end
        wmag_reg <= col_sum[3][SUM_W-1] ? SUM_W'(-col_sum[3]) : SUM_W'(col_sum[3]);
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        hpt_div u_div
        (
            .clk     (clk),
            .num_mag (nmag_reg[i]),
            .den_mag (wmag_reg),
            .neg     (nneg_reg[i]),
            .quo     (quo[i])
        );
    end

    // valid and zero-w flags travel beside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            for (int s = 0; s <= DIV_STAGES; s++)
                side_reg[s] <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[0], start};
            side_reg[0].vld <= vld_reg[1];
            side_reg[0].wz  <= (col_sum[3] == '0);
            for (int s = 1; s <= DIV_STAGES; s++)
                side_reg[s] <= side_reg[s-1];
            done_reg <= side_reg[DIV_STAGES].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        wz_reg <= side_reg[DIV_STAGES].wz;
        rx_reg <= side_reg[DIV_STAGES].wz ? '0 : quo[0];
        ry_reg <= side_reg[DIV_STAGES].wz ? '0 : quo[1];
        rz_reg <= side_reg[DIV_STAGES].wz ? '0 : quo[2];
    end

    assign done     = done_reg;
    assign w_zero   = done_reg & wz_reg;
    assign result_x = rx_reg;
    assign result_y = ry_reg;
    assign result_z = rz_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LAT done)
        else $error("request did not produce a result on time");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LAT))
        else $error("result without a request");

    a_wz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && w_zero) |-> (result_x == 0 && result_y == 0 && result_z == 0))
        else $error("zero w result not cleared");
endmodule
`default_nettype wire
